[rtl/core/ddays_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddays_pkg
// Shared types, constants and the month table for the date difference block.
// ----------------------------------------------------------------------------
package ddays_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned COUNT_W  = 22;
    localparam int unsigned SERIAL_W = 23;
    localparam int unsigned DOY_W    = 9;

    // Reciprocal of 25 scaled by 2^18, exact for dividends below 4200.
    localparam logic [13:0] RECIP_25    = 14'd10486;
    localparam int unsigned RECIP_SHIFT = 18;

    localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 23'd365;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } dates_t;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               order_error;
    } result_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // Load enables for the three stages of the serial day calculation.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Days in the months before the given month; months above twelve count the whole year.
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/ddays_serial.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddays_serial
// Three-stage pipeline turning one date into its serial day number.
// ----------------------------------------------------------------------------
module ddays_serial (
    input  wire logic                            clk,
    input  wire ddays_pkg::stage_en_t            en,
    input  wire ddays_pkg::date_t                date,
    output logic [ddays_pkg::SERIAL_W-1:0]       serial
);

    localparam int unsigned PROD_W = 27;
    localparam int unsigned SH     = ddays_pkg::RECIP_SHIFT;

    // Stage 1: quotients by 100 and 400 through the reciprocal of 25.
    logic [13:0]       yc;
    logic [10:0]       yd;
    logic [PROD_W-1:0] pf, pc, pd;

    logic [13:0] yr_reg,  yr_next;
    logic        mbig_reg, mbig_next;
    logic [8:0]  cum_reg, cum_next;
    logic [4:0]  day_reg, day_next;
    logic [7:0]  qf_reg,  qf_next;
    logic [7:0]  qc_reg,  qc_next;
    logic [5:0]  qd_reg,  qd_next;

    always_comb
    begin
        yc        = 14'((15'(date.year) + 15'd99) >> 2);
        yd        = 11'((15'(date.year) + 15'd399) >> 4);
        pf        = PROD_W'(date.year[13:2]) * PROD_W'(ddays_pkg::RECIP_25);
        pc        = PROD_W'(yc) * PROD_W'(ddays_pkg::RECIP_25);
        pd        = PROD_W'(yd) * PROD_W'(ddays_pkg::RECIP_25);
        yr_next   = date.year;
        mbig_next = (date.month > 4'd2);
        cum_next  = ddays_pkg::cum_days(date.month);
        day_next  = date.day;
        qf_next   = pf[SH+7:SH];
        qc_next   = pc[SH+7:SH];
        qd_next   = pd[SH+5:SH];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            yr_reg   <= yr_next;
            mbig_reg <= mbig_next;
            cum_reg  <= cum_next;
            day_reg  <= day_next;
            qf_reg   <= qf_next;
            qc_reg   <= qc_next;
            qd_reg   <= qd_next;
        end
    end

    // Stage 2: leap rule, day of year and whole years in days.
    logic [11:0] q25, rem;
    logic        div4, div100, leap;

    logic [22:0] y365_reg, y365_next;
    logic [12:0] yq4_reg,  yq4_next;
    logic [7:0]  qc2_reg,  qc2_next;
    logic [5:0]  qd2_reg,  qd2_next;
    logic [8:0]  doy_reg,  doy_next;

    always_comb
    begin
        q25       = (12'(qf_reg) << 4) + (12'(qf_reg) << 3) + 12'(qf_reg);
        rem       = yr_reg[13:2] - q25;
        div4      = (yr_reg[1:0] == 2'd0);
        div100    = div4 && (rem == 12'd0);
        leap      = div4 && (!div100 || (qf_reg[1:0] == 2'd0));
        y365_next = 23'(yr_reg) * ddays_pkg::DAYS_PER_YEAR;
        yq4_next  = 13'((15'(yr_reg) + 15'd3) >> 2);
        qc2_next  = qc_reg;
        qd2_next  = qd_reg;
        doy_next  = cum_reg + 9'(day_reg) + 9'(leap && mbig_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            y365_reg <= y365_next;
            yq4_reg  <= yq4_next;
            qc2_reg  <= qc2_next;
            qd2_reg  <= qd2_next;
            doy_reg  <= doy_next;
        end
    end

    // Stage 3: sum into the serial day number.
    logic [22:0] serial_reg, serial_next;

    always_comb
    begin
        serial_next = y365_reg + 23'(yq4_reg) - 23'(qc2_reg) + 23'(qd2_reg) + 23'(doy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            serial_reg <= serial_next;
        end
    end

    assign serial = serial_reg;

endmodule
`default_nettype wire

[rtl/core/ddays_diff.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddays_diff
// Final stage: order check, subtraction and saturation into the result.
// ----------------------------------------------------------------------------
module ddays_diff (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [ddays_pkg::SERIAL_W-1:0]    start_serial,
    input  wire logic [ddays_pkg::SERIAL_W-1:0]    end_serial,
    output ddays_pkg::result_t                     result
);

    logic [ddays_pkg::SERIAL_W-1:0] diff;
    ddays_pkg::result_t             result_reg, result_next;

    always_comb
    begin
        diff = end_serial - start_serial;
        if (end_serial < start_serial)
        begin
            result_next.day_count   = '0;
            result_next.order_error = 1'b1;
        end
        else
        begin
            // A difference too large for the count field saturates to all ones.
            result_next.day_count   = diff[ddays_pkg::SERIAL_W-1] ? '1
                                      : diff[ddays_pkg::COUNT_W-1:0];
            result_next.order_error = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

[rtl/core/date_difference_days.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// date_difference_days
// Days from a start date to an end date in the Gregorian calendar.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload             Handshake
//  dates    in         ddays_pkg::dates_t  dates_valid / dates_stall
//  result   out        ddays_pkg::result_t result_valid / result_stall
//
//  One pair of dates is taken per cycle while dates_stall is low; a result is
//  presented once its pair has passed the register stages, and is taken at
//  a rising edge when the output is not stalled. Each pair passes through
//  four register stages: quotients, leap and day of year, serial sum, and
//  the difference stage that is also the output register.
//  Reset clears only the valid bits; payload registers are not reset.
//  A stall on the result side holds the output and backs up through the
//  stages, each of which still fills its bubbles, so dates_stall rises only
//  when every stage holds an item.
// ----------------------------------------------------------------------------
module date_difference_days (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                dates_valid,
    output logic                     dates_stall,
    input  wire ddays_pkg::dates_t   dates,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output ddays_pkg::result_t       result
);

    // Valid bits that travel alongside the data through the stages.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic out_valid_reg, out_valid_next;

    // A stage may load when it is empty or the stage after it moves on.
    logic adv1, adv2, adv3, adv_out;

    always_comb
    begin
        adv_out = !out_valid_reg || !result_stall;
        adv3    = !v3_reg || adv_out;
        adv2    = !v2_reg || adv3;
        adv1    = !v1_reg || adv2;

        v1_next        = adv1    ? dates_valid : v1_reg;
        v2_next        = adv2    ? v1_reg      : v2_reg;
        v3_next        = adv3    ? v2_reg      : v3_reg;
        out_valid_next = adv_out ? v3_reg      : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    ddays_pkg::stage_en_t en;
    ddays_pkg::date_t     start_date, end_date;
    logic [ddays_pkg::SERIAL_W-1:0] start_serial, end_serial;

    always_comb
    begin
        en.s1            = adv1;
        en.s2            = adv2;
        en.s3            = adv3;
        start_date.year  = dates.start_year;
        start_date.month = dates.start_month;
        start_date.day   = dates.start_day;
        end_date.year    = dates.end_year;
        end_date.month   = dates.end_month;
        end_date.day     = dates.end_day;
    end

    // Both dates run through identical serial day pipelines side by side.
    ddays_serial u_start (
        .clk    (clk),
        .en     (en),
        .date   (start_date),
        .serial (start_serial)
    );

    ddays_serial u_end (
        .clk    (clk),
        .en     (en),
        .date   (end_date),
        .serial (end_serial)
    );

    ddays_diff u_diff (
        .clk          (clk),
        .en           (adv_out),
        .start_serial (start_serial),
        .end_serial   (end_serial),
        .result       (result)
    );

    assign dates_stall  = !adv1;
    assign result_valid = out_valid_reg;

`ifndef SYNTHESIS
    // The input is held back only while every stage is occupied.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        dates_stall |-> (v1_reg && v2_reg && v3_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // An item in the last serial stage moves into the output when that is free.
    a_stage3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && adv_out) |=> out_valid_reg)
        else $error("item lost between serial stage and output");

    // An accepted pair with a free path reaches the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (dates_valid && !dates_stall) |=> v1_reg)
        else $error("accepted dates did not enter the pipeline");

    // A wrong order always comes with a zero count.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.order_error) |-> (result.day_count == '0))
        else $error("order error with non-zero count");
`endif

endmodule
`default_nettype wire
